// File: hw/rtl/bbtc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbtc_pkg: shared types and constants of the buffer tag cache
// Slot count, field widths, command and status codes, and the structs that
// run between the slot cells and the top level.
// ----------------------------------------------------------------------------
package bbtc_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int IDX_W     = $clog2(NUM_SLOTS);
	localparam int DEV_W     = 8;
	localparam int BLK_W     = 24;
	localparam int CNT_W     = 8;
	localparam int SLOT_W    = 4;
	localparam int STAT_W    = 3;
	localparam int CMD_W     = 2;
	// common width for comparing a requested slot against a cell index
	localparam int CMP_W     = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	// commands
	localparam logic [CMD_W-1:0] CMD_GET     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DROP    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE    = 2'd3;

	// result status codes
	localparam logic [STAT_W-1:0] ST_HIT      = 3'd0;
	localparam logic [STAT_W-1:0] ST_FILLED   = 3'd1;
	localparam logic [STAT_W-1:0] ST_REPLACED = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOFREE   = 3'd3;
	localparam logic [STAT_W-1:0] ST_RELEASED = 3'd4;
	localparam logic [STAT_W-1:0] ST_DROPPED  = 3'd5;

	// one request as held in the pipeline
	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [DEV_W-1:0]  dev;
		logic [BLK_W-1:0]  blk;
		logic [SLOT_W-1:0] slot;
	} bbtc_req_t;

	// global decision signals broadcast to every cell
	typedef struct packed {
		logic fire;
		logic any_hit;
		logic any_empty;
	} bbtc_ctl_t;

	// result bus, OR-collected along the row
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [CNT_W-1:0] refs;
		logic             ev;
		logic [DEV_W-1:0] ev_dev;
		logic [BLK_W-1:0] ev_blk;
	} bbtc_bus_t;

	// chain running from slot 0 upward: lower hit seen, result bus
	typedef struct packed {
		logic      hit;
		bbtc_bus_t bus;
	} bbtc_up_t;

	// chain running from the top slot downward: higher free slots seen
	typedef struct packed {
		logic empty;
		logic unused;
	} bbtc_dn_t;

endpackage
`default_nettype wire

// File: hw/rtl/bbtc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbtc_in_if: request channel
// Valid/ready handshake carrying one command word.
// ----------------------------------------------------------------------------
interface bbtc_in_if;
	logic                        valid;
	logic                        ready;
	logic [bbtc_pkg::CMD_W-1:0]  command;
	logic [bbtc_pkg::DEV_W-1:0]  device;
	logic [bbtc_pkg::BLK_W-1:0]  block_number;
	logic [bbtc_pkg::SLOT_W-1:0] slot;

	modport source (output valid, command, device, block_number, slot, input ready);
	modport sink   (input valid, command, device, block_number, slot, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bbtc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbtc_out_if: response channel
// Valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface bbtc_out_if;
	logic                        valid;
	logic                        ready;
	logic [bbtc_pkg::STAT_W-1:0] status;
	logic [bbtc_pkg::SLOT_W-1:0] slot_index;
	logic [bbtc_pkg::CNT_W-1:0]  ref_count;
	logic                        evicted;
	logic [bbtc_pkg::DEV_W-1:0]  evicted_device;
	logic [bbtc_pkg::BLK_W-1:0]  evicted_block;

	modport source (output valid, status, slot_index, ref_count, evicted,
		evicted_device, evicted_block, input ready);
	modport sink   (input valid, status, slot_index, ref_count, evicted,
		evicted_device, evicted_block, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/block_buffer_tag_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_buffer_tag_cache: fully associative buffer tag table
// Row of slot cells with lookup, fill, replace, release and drop.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command word (get, release or drop); rsp returns one
//   result word per get, release or drop. Command code 3 is absorbed and
//   gives no result word.
//   Stage 1 compares the tag in every cell; stage 2 runs the priority
//   chains along the cell row, updates the chosen slot and loads the
//   output register. No word is taken while another sits in stage 1;
//   the next word is taken at the earliest in the cycle its predecessor
//   leaves stage 2, so it sees the updated table.
//   Reset clears the whole table (all slots invalid, tags and counts zero)
//   at once; no clearing pass is needed.
//   When rsp stalls, the finished word waits in the output register, the
//   next word can still enter and stop in stage 2, and req then drops ready
//   until the output register frees up.
// ----------------------------------------------------------------------------
module block_buffer_tag_cache (
	input  wire        clk,
	input  wire        arst_n,
	bbtc_in_if.sink    req,
	bbtc_out_if.source rsp
);
	import bbtc_pkg::*;

	logic      s1_v_q, s2_v_q;
	bbtc_req_t req_s1, req_s2;
	logic      accept, s2_go;
	bbtc_ctl_t ctl;

	bbtc_up_t up [NUM_SLOTS+1];
	bbtc_dn_t dn [NUM_SLOTS+1];
	logic [NUM_SLOTS-1:0] sel_vec;

	logic any_unused;
	logic [STAT_W-1:0] status_d;
	bbtc_bus_t bus;

	logic              out_v_q;
	logic [STAT_W-1:0] status_q;
	logic [SLOT_W-1:0] slot_index_q;
	logic [CNT_W-1:0]  ref_count_q;
	logic              evicted_q;
	logic [DEV_W-1:0]  ev_dev_q;
	logic [BLK_W-1:0]  ev_blk_q;

	// handshake
	assign s2_go     = !out_v_q || rsp.ready;
	assign req.ready = !s1_v_q && (!s2_v_q || s2_go);
	assign accept    = req.valid && req.ready;

	assign ctl.fire = s2_v_q && s2_go;

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			s1_v_q <= accept;
			if (s1_v_q) begin
				s2_v_q <= 1'b1;
			end else if (ctl.fire) begin
				s2_v_q <= 1'b0;
			end
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.cmd  <= req.command;
			req_s1.dev  <= req.device;
			req_s1.blk  <= req.block_number;
			req_s1.slot <= req.slot;
		end
		if (s1_v_q) begin
			req_s2 <= req_s1;
		end
	end

	// chain ends
	assign up[0]         = '0;
	assign dn[NUM_SLOTS] = '0;

	// row of slot cells
	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		bbtc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (IDX_W'(i)),
			.load_s1 (s1_v_q),
			.req_s1  (req_s1),
			.req_s2  (req_s2),
			.ctl     (ctl),
			.up_in   (up[i]),
			.up_out  (up[i+1]),
			.dn_in   (dn[i+1]),
			.dn_out  (dn[i]),
			.sel     (sel_vec[i])
		);
	end

	assign ctl.any_hit   = up[NUM_SLOTS].hit;
	assign ctl.any_empty = dn[0].empty;
	assign any_unused    = dn[0].unused;
	assign bus           = up[NUM_SLOTS].bus;

	// result status
	always_comb begin
		unique case (req_s2.cmd)
			CMD_GET: begin
				priority if (ctl.any_hit)   status_d = ST_HIT;
				else if (ctl.any_empty)     status_d = ST_FILLED;
				else if (any_unused)        status_d = ST_REPLACED;
				else                        status_d = ST_NOFREE;
			end
			CMD_RELEASE: status_d = ST_RELEASED;
			CMD_DROP:    status_d = ST_DROPPED;
			default:     status_d = ST_NOFREE;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (ctl.fire && (req_s2.cmd != CMD_NONE)) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fire && (req_s2.cmd != CMD_NONE)) begin
			status_q     <= status_d;
			slot_index_q <= (req_s2.cmd == CMD_GET) ? SLOT_W'(bus.idx) : req_s2.slot;
			ref_count_q  <= bus.refs;
			evicted_q    <= bus.ev;
			ev_dev_q     <= bus.ev_dev;
			ev_blk_q     <= bus.ev_blk;
		end
	end

	assign rsp.valid          = out_v_q;
	assign rsp.status         = status_q;
	assign rsp.slot_index     = slot_index_q;
	assign rsp.ref_count      = ref_count_q;
	assign rsp.evicted        = evicted_q;
	assign rsp.evicted_device = ev_dev_q;
	assign rsp.evicted_block  = ev_blk_q;

`ifndef SYNTHESIS
	// at most one cell acts on a word
	a_one_sel: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v_q |-> $onehot0(sel_vec))
		else $error("more than one slot selected");

	// no free slot means no cell was touched
	a_nofree_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_v_q && (req_s2.cmd == CMD_GET) && (status_d == ST_NOFREE)) |-> (sel_vec == '0))
		else $error("slot selected on no-free result");

	// stage 1 always advances into stage 2
	a_s1_adv: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q |=> (s2_v_q && !s1_v_q))
		else $error("stage 1 did not advance");

	// evicted tag fields are zero unless an eviction is reported
	a_ev_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !evicted_q) |-> ((ev_dev_q == '0) && (ev_blk_q == '0)))
		else $error("evicted tag without eviction");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/bbtc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbtc_cell: one buffer slot
// Holds valid, tags and reference count. Compares the tag in stage 1,
// then takes part in the priority chains and drives the result bus in
// stage 2, updating its own entry when the word completes.
// ----------------------------------------------------------------------------
module bbtc_cell (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire [bbtc_pkg::IDX_W-1:0]    idx,
	input  wire                          load_s1,
	input  wire bbtc_pkg::bbtc_req_t     req_s1,
	input  wire bbtc_pkg::bbtc_req_t     req_s2,
	input  wire bbtc_pkg::bbtc_ctl_t     ctl,
	input  wire bbtc_pkg::bbtc_up_t      up_in,
	output bbtc_pkg::bbtc_up_t           up_out,
	input  wire bbtc_pkg::bbtc_dn_t      dn_in,
	output bbtc_pkg::bbtc_dn_t           dn_out,
	output logic                         sel
);
	import bbtc_pkg::*;

	logic             valid_q;
	logic [DEV_W-1:0] dev_q;
	logic [BLK_W-1:0] blk_q;
	logic [CNT_W-1:0] refs_q;

	logic hit_s2, empty_s2, unused_s2;

	logic is_get, is_rel, is_drop, slot_hit;
	logic win_hit, win_fill, win_rep, rel_sel, drop_sel;
	logic [CNT_W-1:0] new_refs;
	bbtc_bus_t mine;

	// stage 1: tag compare and free-slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s2    <= 1'b0;
			empty_s2  <= 1'b0;
			unused_s2 <= 1'b0;
		end else if (load_s1) begin
			hit_s2    <= valid_q && (dev_q == req_s1.dev) && (blk_q == req_s1.blk);
			empty_s2  <= !valid_q;
			unused_s2 <= valid_q && (refs_q == '0);
		end
	end

	// stage 2: decode and priority
	always_comb begin
		is_get   = (req_s2.cmd == CMD_GET);
		is_rel   = (req_s2.cmd == CMD_RELEASE);
		is_drop  = (req_s2.cmd == CMD_DROP);
		slot_hit = (CMP_W'(req_s2.slot) == CMP_W'(idx));
		// lowest matching slot wins a hit
		win_hit  = is_get && hit_s2 && !up_in.hit;
		// highest empty slot, else highest unreferenced slot
		win_fill = is_get && !ctl.any_hit && empty_s2 && !dn_in.empty;
		win_rep  = is_get && !ctl.any_hit && !ctl.any_empty && unused_s2 && !dn_in.unused;
		rel_sel  = is_rel && slot_hit;
		drop_sel = is_drop && slot_hit;
		sel      = win_hit || win_fill || win_rep || rel_sel || drop_sel;
	end

	// count after the step
	always_comb begin
		priority if (win_hit) begin
			new_refs = (refs_q == CNT_MAX) ? refs_q : refs_q + CNT_ONE;
		end else if (win_fill || win_rep) begin
			new_refs = CNT_ONE;
		end else if (rel_sel) begin
			new_refs = (refs_q != '0) ? refs_q - CNT_ONE : refs_q;
		end else if (drop_sel) begin
			new_refs = '0;
		end else begin
			new_refs = refs_q;
		end
	end

	// own contribution to the result bus, zero unless selected
	always_comb begin
		mine = '0;
		if (sel) begin
			mine.idx  = idx;
			mine.refs = new_refs;
			mine.ev   = valid_q && (drop_sel || win_rep);
			if (mine.ev) begin
				mine.ev_dev = dev_q;
				mine.ev_blk = blk_q;
			end
		end
	end

	// hand-off to neighbors
	assign up_out.hit    = up_in.hit | hit_s2;
	assign up_out.bus    = up_in.bus | mine;
	assign dn_out.empty  = dn_in.empty | empty_s2;
	assign dn_out.unused = dn_in.unused | unused_s2;

	// entry update when the word completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dev_q   <= '0;
			blk_q   <= '0;
			refs_q  <= '0;
		end else if (ctl.fire && sel) begin
			refs_q <= new_refs;
			if (win_fill || win_rep) begin
				valid_q <= 1'b1;
				dev_q   <= req_s2.dev;
				blk_q   <= req_s2.blk;
			end else if (drop_sel) begin
				valid_q <= 1'b0;
				dev_q   <= '0;
				blk_q   <= '0;
			end
		end
	end

endmodule
`default_nettype wire
